// ===== rtl/core/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the tick-level I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_WRITE = 3'd4;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] BITS_ACK_DONE = 4'd9;
    localparam logic [7:0] POLL_LIMIT_RESET = 8'd255;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       final_read;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] phase;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic [7:0] poll_count;
        logic       scl;
        logic       sda;
        logic       sda_dir;
        logic       ack_flag;
        logic       last_nack;
        logic [7:0] rx_hold;
    } state_t;

    localparam state_t STATE_RESET = '{
        op:         OP_IDLE,
        phase:      3'd0,
        bit_count:  4'd0,
        shift_byte: 8'd0,
        poll_count: 8'd0,
        scl:        1'b1,
        sda:        1'b1,
        sda_dir:    1'b1,
        ack_flag:   1'b0,
        last_nack:  1'b0,
        rx_hold:    8'd0
    };

endpackage

`default_nettype wire

// ===== rtl/core/i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Byte-level I2C master stepped one bit-phase tick per transfer.
// ----------------------------------------------------------------------------
// Every transfer on the item channel is one delay tick and returns exactly one
// result transfer holding the pin levels after that tick. Ticks go through an
// input register and a result register, so a tick is accepted every cycle
// unless results stall, its result appears once it has passed both registers,
// and the sequencer state is updated once per tick by combinational logic.
// Commands are only taken while ready_res of the previous result was 1; a
// command given while busy is dropped. Write ack_poll_limit over the cfg
// channel only when no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [2:0] cmd,
    input  logic [7:0] tx_byte,
    input  logic       final_read,
    input  logic       sda_in,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       scl_level,
    output logic       sda_level,
    output logic       sda_drive,
    output logic       ready_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       acked,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import i2cm_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       done_next;
    logic [7:0] poll_limit_reg;
    logic       res_valid_reg;
    logic       advance;

    assign advance    = !res_valid_reg || res_ready;
    assign item_ready = !in_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    i2cm_step u_step (
        .cur        (state_reg),
        .item       (in_item_reg),
        .poll_limit (poll_limit_reg),
        .nxt        (state_next),
        .done       (done_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= POLL_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            poll_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= '{cmd: cmd, tx_byte: tx_byte,
                             final_read: final_read, sda_in: sda_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            done_res      <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                    done_res  <= done_next;
                end
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign scl_level = state_reg.scl;
    assign sda_level = state_reg.sda;
    assign sda_drive = state_reg.sda_dir;
    assign ready_res = (state_reg.op == OP_IDLE);
    assign rx_byte   = state_reg.rx_hold;
    assign acked     = state_reg.ack_flag;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> ready_res)
        else $error("done without returning to idle");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.op == OP_IDLE |-> state_reg.phase == 3'd0 && state_reg.bit_count == 4'd0)
        else $error("idle with stale phase or bit count");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_count <= BITS_ACK_DONE)
        else $error("bit count out of range");

    a_release_op: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.sda_dir |-> state_reg.op == OP_READ || state_reg.op == OP_WRITE)
        else $error("SDA released outside a byte transfer");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(state_reg))
        else $error("state moved while result stalled");

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// i2cm_step
// One tick of the sequencer: command take-over and the pin action.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_step (
    input  i2cm_pkg::state_t cur,
    input  i2cm_pkg::item_t  item,
    input  logic [7:0]       poll_limit,
    output i2cm_pkg::state_t nxt,
    output logic             done
);
    import i2cm_pkg::*;

    always_comb
    begin
        state_t     s;
        logic       fin;
        logic [3:0] bc_inc;
        logic [7:0] pc_inc;

        s      = cur;
        fin    = 1'b0;
        bc_inc = cur.bit_count + 4'd1;
        pc_inc = cur.poll_count + 8'd1;

        if (cur.op == OP_IDLE && item.cmd >= OP_START && item.cmd <= OP_WRITE)
        begin
            s.op         = item.cmd;
            s.phase      = 3'd0;
            s.bit_count  = 4'd0;
            s.poll_count = 8'd0;
            bc_inc       = 4'd1;
            pc_inc       = 8'd1;
            if (item.cmd == OP_READ)
            begin
                s.shift_byte = 8'd0;
                s.last_nack  = item.final_read;
            end
            else if (item.cmd == OP_WRITE)
            begin
                s.shift_byte = item.tx_byte;
                s.ack_flag   = 1'b0;
            end
        end

        unique case (s.op)
            OP_START:
            begin
                unique case (s.phase)
                    3'd0:    s.sda = 1'b1;
                    3'd1:    s.scl = 1'b1;
                    3'd2:    s.sda = 1'b0;
                    default:
                    begin
                        s.scl = 1'b0;
                        fin   = 1'b1;
                    end
                endcase
                s.phase = s.phase + 3'd1;
            end
            OP_STOP:
            begin
                unique case (s.phase)
                    3'd0:    s.sda = 1'b0;
                    3'd1:    s.scl = 1'b0;
                    3'd2:    s.scl = 1'b1;
                    default:
                    begin
                        s.sda = 1'b1;
                        fin   = 1'b1;
                    end
                endcase
                s.phase = s.phase + 3'd1;
            end
            OP_READ:
            begin
                unique case (s.phase)
                    3'd0:
                    begin
                        s.sda_dir = 1'b0;
                        s.scl     = 1'b0;
                        s.phase   = 3'd1;
                    end
                    3'd1:
                    begin
                        s.scl   = 1'b1;
                        s.phase = 3'd2;
                    end
                    3'd2:    s.phase = 3'd3;
                    3'd3:
                    begin
                        s.shift_byte = {s.shift_byte[6:0], item.sda_in};
                        s.scl        = 1'b0;
                        s.bit_count  = bc_inc;
                        s.phase      = (bc_inc >= BITS_PER_BYTE) ? 3'd4 : 3'd0;
                    end
                    3'd4:
                    begin
                        s.sda_dir = 1'b1;
                        s.scl     = 1'b0;
                        s.phase   = 3'd5;
                    end
                    3'd5:
                    begin
                        s.sda   = s.last_nack;
                        s.phase = 3'd6;
                    end
                    3'd6:
                    begin
                        s.scl   = 1'b1;
                        s.phase = 3'd7;
                    end
                    default:
                    begin
                        s.scl     = 1'b0;
                        s.rx_hold = s.shift_byte;
                        fin       = 1'b1;
                    end
                endcase
            end
            OP_WRITE:
            begin
                unique case (s.phase)
                    3'd0:
                    begin
                        s.scl   = 1'b0;
                        s.phase = 3'd1;
                    end
                    3'd1:
                    begin
                        s.sda        = s.shift_byte[7];
                        s.shift_byte = {s.shift_byte[6:0], 1'b0};
                        s.phase      = 3'd2;
                    end
                    3'd2:
                    begin
                        s.scl   = 1'b1;
                        s.phase = 3'd3;
                    end
                    3'd3:
                    begin
                        s.scl       = 1'b0;
                        s.bit_count = bc_inc;
                        s.phase     = (bc_inc >= BITS_PER_BYTE) ? 3'd4 : 3'd1;
                    end
                    3'd4:
                    begin
                        s.sda_dir = 1'b0;
                        s.sda     = 1'b1;
                        s.phase   = 3'd5;
                    end
                    3'd5:
                    begin
                        s.scl        = 1'b1;
                        s.poll_count = 8'd0;
                        s.phase      = 3'd6;
                    end
                    3'd6:
                    begin
                        if (!item.sda_in)
                        begin
                            s.ack_flag = 1'b1;
                            s.phase    = 3'd7;
                        end
                        else
                        begin
                            s.poll_count = pc_inc;
                            if (pc_inc >= poll_limit)
                            begin
                                s.phase = 3'd7;
                            end
                        end
                    end
                    default:
                    begin
                        if (s.bit_count == BITS_PER_BYTE)
                        begin
                            s.scl       = 1'b0;
                            s.bit_count = BITS_ACK_DONE;
                        end
                        else
                        begin
                            s.sda_dir = 1'b1;
                            s.sda     = 1'b1;
                            fin       = 1'b1;
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (fin)
        begin
            s.op        = OP_IDLE;
            s.phase     = 3'd0;
            s.bit_count = 4'd0;
        end

        nxt  = s;
        done = fin;
    end

endmodule

`default_nettype wire

// ===== verif/i2c_master_bit_engine_checker.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_checker
// Watches the tick, result and config channels of the I2C bit engine, keeps
// its own model of the bus sequencer, and compares every result transfer
// against the oldest predicted pin state. Failures are counted for the top.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_ready,
    input  logic [2:0] cmd,
    input  logic [7:0] tx_byte,
    input  logic       final_read,
    input  logic       sda_in,
    input  logic       res_valid,
    input  logic       res_ready,
    input  logic       scl_level,
    input  logic       sda_level,
    input  logic       sda_drive,
    input  logic       ready_res,
    input  logic       done_res,
    input  logic [7:0] rx_byte,
    input  logic       acked,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    output int         fail_count,
    output int         pending,
    output int         checked
);

    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] ph;
        logic [3:0] nbits;
        logic [7:0] shreg;
        logic [7:0] polls;
        logic       scl;
        logic       sda;
        logic       drv;
        logic       ackf;
        logic       nack;
        logic [7:0] rxb;
    } bus_state_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drv;
        logic       rdy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } pins_t;

    bus_state_t bus;
    logic [7:0] poll_limit;
    pins_t      pin_expect_q[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got 0x%0h want 0x%0h (result %0d)",
                 $realtime, what, got, want, checked);
        fail_count++;
    endtask

    function automatic pins_t advance_bus(input logic [2:0] c, input logic [7:0] tx,
                                          input logic fr, input logic sdi);
        pins_t p;
        logic  fin;
        fin = 1'b0;
        if (bus.op == OP_IDLE && c >= OP_START && c <= OP_WRITE) begin
            bus.op    = c;
            bus.ph    = 3'd0;
            bus.nbits = 4'd0;
            bus.polls = 8'd0;
            if (c == OP_READ) begin
                bus.shreg = 8'd0;
                bus.nack  = fr;
            end
            else if (c == OP_WRITE) begin
                bus.shreg = tx;
                bus.ackf  = 1'b0;
            end
        end
        case (bus.op)
            OP_START:
            begin
                case (bus.ph)
                    3'd0: bus.sda = 1'b1;
                    3'd1: bus.scl = 1'b1;
                    3'd2: bus.sda = 1'b0;
                    default:
                    begin
                        bus.scl = 1'b0;
                        fin     = 1'b1;
                    end
                endcase
                bus.ph = bus.ph + 3'd1;
            end
            OP_STOP:
            begin
                case (bus.ph)
                    3'd0: bus.sda = 1'b0;
                    3'd1: bus.scl = 1'b0;
                    3'd2: bus.scl = 1'b1;
                    default:
                    begin
                        bus.sda = 1'b1;
                        fin     = 1'b1;
                    end
                endcase
                bus.ph = bus.ph + 3'd1;
            end
            OP_READ:
            begin
                case (bus.ph)
                    3'd0:
                    begin
                        bus.drv = 1'b0;
                        bus.scl = 1'b0;
                        bus.ph  = 3'd1;
                    end
                    3'd1:
                    begin
                        bus.scl = 1'b1;
                        bus.ph  = 3'd2;
                    end
                    3'd2: bus.ph = 3'd3;
                    3'd3:
                    begin
                        bus.shreg = {bus.shreg[6:0], sdi};
                        bus.scl   = 1'b0;
                        bus.nbits = bus.nbits + 4'd1;
                        bus.ph    = (bus.nbits >= BITS_PER_BYTE) ? 3'd4 : 3'd0;
                    end
                    3'd4:
                    begin
                        bus.drv = 1'b1;
                        bus.scl = 1'b0;
                        bus.ph  = 3'd5;
                    end
                    3'd5:
                    begin
                        bus.sda = bus.nack;
                        bus.ph  = 3'd6;
                    end
                    3'd6:
                    begin
                        bus.scl = 1'b1;
                        bus.ph  = 3'd7;
                    end
                    default:
                    begin
                        bus.scl = 1'b0;
                        bus.rxb = bus.shreg;
                        fin     = 1'b1;
                    end
                endcase
            end
            OP_WRITE:
            begin
                case (bus.ph)
                    3'd0:
                    begin
                        bus.scl = 1'b0;
                        bus.ph  = 3'd1;
                    end
                    3'd1:
                    begin
                        bus.sda   = bus.shreg[7];
                        bus.shreg = {bus.shreg[6:0], 1'b0};
                        bus.ph    = 3'd2;
                    end
                    3'd2:
                    begin
                        bus.scl = 1'b1;
                        bus.ph  = 3'd3;
                    end
                    3'd3:
                    begin
                        bus.scl   = 1'b0;
                        bus.nbits = bus.nbits + 4'd1;
                        bus.ph    = (bus.nbits >= BITS_PER_BYTE) ? 3'd4 : 3'd1;
                    end
                    3'd4:
                    begin
                        bus.drv = 1'b0;
                        bus.sda = 1'b1;
                        bus.ph  = 3'd5;
                    end
                    3'd5:
                    begin
                        bus.scl   = 1'b1;
                        bus.polls = 8'd0;
                        bus.ph    = 3'd6;
                    end
                    3'd6:
                    begin
                        if (!sdi) begin
                            bus.ackf = 1'b1;
                            bus.ph   = 3'd7;
                        end
                        else begin
                            bus.polls = bus.polls + 8'd1;
                            if (bus.polls >= poll_limit)
                                bus.ph = 3'd7;
                        end
                    end
                    default:
                    begin
                        // ack clock low first, then hand SDA back
                        if (bus.nbits == BITS_PER_BYTE) begin
                            bus.scl   = 1'b0;
                            bus.nbits = BITS_ACK_DONE;
                        end
                        else begin
                            bus.drv = 1'b1;
                            bus.sda = 1'b1;
                            fin     = 1'b1;
                        end
                    end
                endcase
            end
            default: ;
        endcase
        if (fin) begin
            bus.op    = OP_IDLE;
            bus.ph    = 3'd0;
            bus.nbits = 4'd0;
        end
        p.scl  = bus.scl;
        p.sda  = bus.sda;
        p.drv  = bus.drv;
        p.rdy  = (bus.op == OP_IDLE);
        p.done = fin;
        p.rx   = bus.rxb;
        p.ack  = bus.ackf;
        return p;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        pins_t want;
        if (!rst_n) begin
            bus.op     = OP_IDLE;
            bus.ph     = 3'd0;
            bus.nbits  = 4'd0;
            bus.shreg  = 8'd0;
            bus.polls  = 8'd0;
            bus.scl    = 1'b1;
            bus.sda    = 1'b1;
            bus.drv    = 1'b1;
            bus.ackf   = 1'b0;
            bus.nack   = 1'b0;
            bus.rxb    = 8'd0;
            poll_limit = POLL_LIMIT_RESET;
            pin_expect_q.delete();
            fail_count = 0;
            checked    = 0;
            pending    = 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                poll_limit = cfg_data;
            if (item_valid && item_ready)
                pin_expect_q.push_back(advance_bus(cmd, tx_byte, final_read, sda_in));
            if (res_valid && res_ready) begin
                if (pin_expect_q.size() == 0) begin
                    report_mismatch("result with nothing expected", rx_byte, 0);
                end
                else begin
                    want = pin_expect_q.pop_front();
                    if (scl_level !== want.scl)
                        report_mismatch("scl_level", scl_level, want.scl);
                    if (sda_level !== want.sda)
                        report_mismatch("sda_level", sda_level, want.sda);
                    if (sda_drive !== want.drv)
                        report_mismatch("sda_drive", sda_drive, want.drv);
                    if (ready_res !== want.rdy)
                        report_mismatch("ready_res", ready_res, want.rdy);
                    if (done_res !== want.done)
                        report_mismatch("done_res", done_res, want.done);
                    if (rx_byte !== want.rx)
                        report_mismatch("rx_byte", rx_byte, want.rx);
                    if (acked !== want.ack)
                        report_mismatch("acked", acked, want.ack);
                end
                checked++;
            end
            pending = pin_expect_q.size();
        end
    end

endmodule

// ===== verif/i2c_master_bit_engine_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Drives bus-tick sequences into the I2C bit engine: start, stop, read and
// write commands with random data and slave responses, broken and overlapping
// commands, and several ack poll limits. Both channels stall at random.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    localparam int RUN_ITEMS    = 850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 36;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 4;
    localparam int CFG_SPAN     = 150;
    localparam int START_TICKS  = 4;
    localparam int STOP_TICKS   = 4;
    localparam int READ_TICKS   = 36;
    localparam int WRITE_TICKS  = 29;
    localparam logic [2:0] CMD_MAX = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       final_read;
    logic       sda_in;
    logic       res_valid;
    logic       res_ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       acked;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;

    int         fail_count;
    int         pending;
    int         checked;
    int         cycles;
    int         ticks_sent;
    int         cfg_writes;
    int         hold_left;
    logic       hold_req;
    logic       hold_done;
    logic       no_idle;
    logic [7:0] poll_limit;

    i2c_master_bit_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .tx_byte    (tx_byte),
        .final_read (final_read),
        .sda_in     (sda_in),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .sda_drive  (sda_drive),
        .ready_res  (ready_res),
        .done_res   (done_res),
        .rx_byte    (rx_byte),
        .acked      (acked),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    i2c_master_bit_engine_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .cmd        (cmd),
        .tx_byte    (tx_byte),
        .final_read (final_read),
        .sda_in     (sda_in),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .scl_level  (scl_level),
        .sda_level  (sda_level),
        .sda_drive  (sda_drive),
        .ready_res  (ready_res),
        .done_res   (done_res),
        .rx_byte    (rx_byte),
        .acked      (acked),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off while ticks keep coming
    initial
    begin
        res_ready = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
    end
    always @(posedge clk)
    begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end
        else if (hold_left > 0) begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done) begin
            res_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else begin
            res_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_tick(input logic [2:0] c, input logic [7:0] tx,
                             input logic fr, input logic sdi);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        cmd        <= c;
        tx_byte    <= tx;
        final_read <= fr;
        sda_in     <= sdi;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        ticks_sent++;
    endtask

    // one command tick, then idle ticks for its expected length (+slack);
    // stray commands that land while busy must be dropped
    task automatic run_command(input logic [2:0] c, input logic [7:0] tx, input logic fr,
                               input int low_pct, input int slack, input int stray_pct);
        int         n;
        logic [2:0] c2;
        case (c)
            OP_START: n = START_TICKS;
            OP_STOP:  n = STOP_TICKS;
            OP_READ:  n = READ_TICKS;
            OP_WRITE: n = WRITE_TICKS + poll_limit;
            default:  n = 1;
        endcase
        n = n + slack;
        if (n < 1)
            n = 1;
        send_tick(c, tx, fr, $urandom_range(99) >= low_pct);
        for (int i = 1; i < n; i++) begin
            c2 = ($urandom_range(99) < stray_pct) ? 3'($urandom_range(CMD_MAX, 1)) : OP_IDLE;
            send_tick(c2, 8'($urandom), 1'($urandom), $urandom_range(99) >= low_pct);
        end
    endtask

    task automatic quiesce;
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        poll_limit = v;
        cfg_writes++;
    endtask

    initial
    begin
        int         base;
        int         next_cfg;
        int         r;
        int         lowp;
        logic [7:0] lim;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        cmd        = OP_IDLE;
        tx_byte    = 8'd0;
        final_read = 1'b0;
        sda_in     = 1'b1;
        cfg_valid  = 1'b0;
        cfg_data   = 8'd0;
        hold_req   = 1'b0;
        no_idle    = 1'b0;
        ticks_sent = 0;
        cfg_writes = 0;
        poll_limit = POLL_LIMIT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unknown codes, each command, ack / no ack at reset limit
        for (int c = OP_WRITE + 1; c <= CMD_MAX; c++)
            send_tick(3'(c), 8'hFF, 1'b1, 1'b0);
        run_command(OP_START, 8'h00, 1'b0, 50, 0, 0);
        run_command(OP_WRITE, 8'hFF, 1'b0, 100, 1 - int'(POLL_LIMIT_RESET), 0);
        run_command(OP_WRITE, 8'h00, 1'b0, 0, 0, 0);
        run_command(OP_READ, 8'h00, 1'b0, 0, 0, 0);
        run_command(OP_READ, 8'hFF, 1'b1, 100, 0, 40);
        run_command(OP_STOP, 8'h00, 1'b0, 50, 0, 0);
        quiesce();
        write_limit(8'd1);
        run_command(OP_START, 8'h00, 1'b0, 50, 0, 0);
        run_command(OP_WRITE, 8'h5A, 1'b0, 0, 0, 0);
        run_command(OP_WRITE, 8'hA5, 1'b1, 50, 0, 20);
        run_command(OP_STOP, 8'hFF, 1'b1, 50, 0, 0);

        // random: mostly whole commands, some cut short, some lone noise ticks
        base     = ticks_sent;
        next_cfg = ticks_sent;
        while (ticks_sent < RUN_ITEMS) begin
            if (ticks_sent >= next_cfg) begin
                quiesce();
                r = $urandom_range(9);
                lim = (r == 0) ? 8'd255 : (r == 1) ? 8'd1 : 8'($urandom_range(12, 2));
                write_limit(lim);
                next_cfg = ticks_sent + CFG_SPAN;
            end
            hold_req = (ticks_sent - base >= 100);
            no_idle  = (ticks_sent - base >= 150) && (ticks_sent - base < 300);
            case ($urandom_range(3))
                0: lowp = 0;
                1: lowp = 30;
                2: lowp = 70;
                default: lowp = 100;
            endcase
            r = $urandom_range(99);
            if (r < 72)
                run_command(3'($urandom_range(OP_WRITE, OP_START)), 8'($urandom),
                            1'($urandom), lowp, $urandom_range(2), 3);
            else if (r < 87)
                run_command(3'($urandom_range(OP_WRITE, OP_START)), 8'($urandom),
                            1'($urandom), lowp, -int'($urandom_range(3, 1)), 3);
            else
                send_tick(3'($urandom_range(CMD_MAX)), 8'($urandom), 1'($urandom),
                          1'($urandom));
        end
        no_idle = 1'b0;
        quiesce();

        $display("Drove %0d bus ticks, compared %0d results, %0d poll limit writes.",
                 ticks_sent, checked, cfg_writes);
        $display("Covered start/stop/read/write, ack and no-ack, busy and unknown commands.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_master_bit_engine.sv
verif/i2c_master_bit_engine_checker.sv
verif/i2c_master_bit_engine_tb.sv
